>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL files (included by mcgrp_queue)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/mcgrp_pkg.sv
// Package: types, constants and match tables of the get response parser
`default_nettype none
package mcgrp_pkg;

  localparam int unsigned KeyMaxDef     = 256;
  localparam int unsigned LengthBitsDef = 48;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [2:0] {
    EV_BODY      = 3'd0,
    EV_HEADER    = 3'd1,
    EV_NOT_FOUND = 3'd2,
    EV_BAD_HDR   = 3'd3,
    EV_BAD_TRL   = 3'd4,
    EV_COMPLETE  = 3'd5
  } event_e;

  typedef struct packed {
    event_e      kind;
    logic [7:0]  body;
    logic [47:0] len;
    logic        gz;
    logic        ka;
  } res_t;

  function automatic logic [7:0] value_word(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h56;
      3'd1: b = 8'h41;
      3'd2: b = 8'h4C;
      3'd3: b = 8'h55;
      3'd4: b = 8'h45;
      3'd5: b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] end_word(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h45;
      3'd1: b = 8'h4E;
      3'd2: b = 8'h44;
      3'd3: b = 8'h0D;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] trailer_word(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h0D;
      3'd1: b = 8'h0A;
      3'd2: b = 8'h45;
      3'd3: b = 8'h4E;
      3'd4: b = 8'h44;
      3'd5: b = 8'h0D;
      3'd6: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/memcached_get_response_parser.sv
// Top level of the memcached text get response parser
// Usage:
//  Input channel (in_valid_i/in_stall_o, mode_i, data_byte_i) carries one byte
//  per transaction: mode 0 loads a key byte and restarts the parser, mode 1 is
//  a response byte. Each transaction yields zero or one result on the output
//  channel (out_valid_o/out_stall_i, event_kind_o and its fields).
//  Results are registered in the result queue; throughput is one byte per
//  cycle while in_stall_o is low. The key RAM read is registered, its address
//  prefetched from the next match index.
//  A two-entry result queue separates parser and receiver; in_stall_o is high
//  only while that queue is full, so a stalled receiver backs up after two
//  pending results.
//  cfg_we_i/cfg_wdata_i write the gzip flag mask; write only while idle.
//  Reset: parser at start of header, key length zero, mask zero, queue empty.
//  Key RAM contents are not cleared; only loaded entries are ever compared.
`default_nettype none
module memcached_get_response_parser #(
  parameter int unsigned KeyMax     = mcgrp_pkg::KeyMaxDef,
  parameter int unsigned LengthBits = mcgrp_pkg::LengthBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_kind_o,
  output logic [7:0]       body_byte_o,
  output logic [47:0]      content_length_o,
  output logic             gzip_encoded_o,
  output logic             keepalive_o
);
  import mcgrp_pkg::*;

  logic full, item, res_valid;
  res_t res, head;

  assign in_stall_o = full;
  assign item       = in_valid_i && !full;

  mcgrp_front #(.KeyMax(KeyMax), .LengthBits(LengthBits)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item),
    .mode_i     (mode_i),
    .data_byte_i(data_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  mcgrp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (head)
  );

  assign event_kind_o     = head.kind;
  assign body_byte_o      = head.body;
  assign content_length_o = head.len;
  assign gzip_encoded_o   = head.gz;
  assign keepalive_o      = head.ka;
endmodule
`default_nettype wire

>>> rtl/core/mcgrp_ram.sv
// Generic single write port RAM with registered read
`default_nettype none
module mcgrp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/core/mcgrp_front.sv
// Front end: key store, header/body/trailer parser, result generation
`default_nettype none
module mcgrp_front #(
  parameter int unsigned KeyMax     = mcgrp_pkg::KeyMaxDef,
  parameter int unsigned LengthBits = mcgrp_pkg::LengthBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               item_i,
  input  wire logic               mode_i,
  input  wire logic [7:0]         data_byte_i,
  output logic                    res_valid_o,
  output mcgrp_pkg::res_t         res_o
);
  import mcgrp_pkg::*;

  localparam int unsigned AW  = (KeyMax > 1) ? $clog2(KeyMax) : 1;
  localparam int unsigned KLW = $clog2(KeyMax + 1);
  localparam int unsigned MW  = (KLW > 3) ? KLW : 3;
  localparam int unsigned LB  = LengthBits;

  localparam logic [3:0] PH_START = 4'd0,  PH_VALUE = 4'd1,  PH_ENDW  = 4'd2,
                         PH_KEY   = 4'd3,  PH_KEYSP = 4'd4,  PH_FANY  = 4'd5,
                         PH_FNUM  = 4'd6,  PH_LEN   = 4'd7,  PH_LENLF = 4'd8,
                         PH_ENDLF = 4'd9,  PH_BAD   = 4'd10, PH_BODY  = 4'd11,
                         PH_TRAIL = 4'd12, PH_DONE  = 4'd13;

  logic [3:0]     phase_q, phase_d;
  logic [KLW-1:0] klen_q, klen_d;
  logic [MW-1:0]  midx_q, midx_d;
  logic [31:0]    flags_q, flags_d;
  logic [LB-1:0]  len_q, len_d;
  logic [LB-1:0]  rem_q, rem_d;
  logic [2:0]     tidx_q, tidx_d;
  logic           dseen_q, dseen_d;
  logic [31:0]    mask_q;

  logic [KLW-1:0] widx;
  logic           ram_we;
  logic [7:0]     key_byte;
  logic [35:0]    fprod;
  logic [LB+3:0]  lprod;
  logic [3:0]     digit;
  logic           is_digit;

  mcgrp_ram #(.Width(8), .Depth(KeyMax), .AddrW(AW)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(widx[AW-1:0]),
    .wdata_i(data_byte_i),
    .raddr_i(midx_d[AW-1:0]),
    .rdata_o(key_byte)
  );

  assign digit    = data_byte_i[3:0];
  assign is_digit = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
  assign fprod    = ({4'b0, flags_q} << 3) + ({4'b0, flags_q} << 1) + 36'(digit);
  assign lprod    = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1) + (LB+4)'(digit);
  assign widx     = (phase_q != PH_START) ? '0 : klen_q;
  assign ram_we   = item_i && !mode_i && (widx < KLW'(KeyMax));

  always_comb begin
    phase_d = phase_q; klen_d = klen_q; midx_d = midx_q; flags_d = flags_q;
    len_d = len_q; rem_d = rem_q; tidx_d = tidx_q; dseen_d = dseen_q;
    res_valid_o = 1'b0;
    res_o = '{kind: EV_BODY, body: 8'h00, len: 48'h0, gz: 1'b0, ka: 1'b0};
    if (item_i) begin
      if (!mode_i) begin
        klen_d  = ram_we ? widx + KLW'(1) : widx;
        phase_d = PH_START; midx_d = '0; flags_d = '0; len_d = '0;
        rem_d = '0; tidx_d = '0; dseen_d = 1'b0;
      end else if (phase_q == PH_DONE) begin
        phase_d = PH_DONE;
      end else if (phase_q == PH_BODY) begin
        rem_d = rem_q - LB'(1);
        if (rem_q == LB'(1)) begin
          phase_d = PH_TRAIL; tidx_d = '0;
        end
        res_valid_o = 1'b1;
        res_o.body  = data_byte_i;
      end else if (phase_q == PH_TRAIL) begin
        if (tidx_q == 3'd7 || data_byte_i != trailer_word(tidx_q)) begin
          phase_d = PH_DONE; res_valid_o = 1'b1; res_o.kind = EV_BAD_TRL;
        end else begin
          tidx_d = tidx_q + 3'd1;
          if (tidx_q == 3'd6) begin
            phase_d = PH_DONE; res_valid_o = 1'b1;
            res_o.kind = EV_COMPLETE; res_o.ka = 1'b1;
          end
        end
      end else if (data_byte_i == 8'h0A) begin
        res_valid_o = 1'b1;
        if (phase_q == PH_ENDLF) begin
          phase_d = PH_DONE; res_o.kind = EV_NOT_FOUND; res_o.ka = 1'b1;
        end else if (phase_q == PH_LENLF) begin
          rem_d = len_q; tidx_d = '0;
          phase_d = (len_q != '0) ? PH_BODY : PH_TRAIL;
          res_o.kind = EV_HEADER;
          res_o.len  = 48'(len_q);
          res_o.gz   = (flags_q & mask_q) != 32'h0;
        end else begin
          phase_d = PH_DONE; res_o.kind = EV_BAD_HDR;
        end
      end else begin
        unique case (phase_q)
          PH_START: begin
            midx_d = MW'(1);
            if (data_byte_i == 8'h56)      phase_d = PH_VALUE;
            else if (data_byte_i == 8'h45) phase_d = PH_ENDW;
            else begin
              phase_d = PH_BAD; midx_d = midx_q;
            end
          end
          PH_VALUE: begin
            if (midx_q >= MW'(6) || data_byte_i != value_word(midx_q[2:0])) begin
              phase_d = PH_BAD;
            end else if (midx_q == MW'(5)) begin
              midx_d  = '0;
              phase_d = (klen_q != '0) ? PH_KEY : PH_KEYSP;
            end else begin
              midx_d = midx_q + MW'(1);
            end
          end
          PH_ENDW: begin
            if (midx_q >= MW'(4) || data_byte_i != end_word(midx_q[2:0])) begin
              phase_d = PH_BAD;
            end else begin
              midx_d = midx_q + MW'(1);
              if (midx_q == MW'(3)) phase_d = PH_ENDLF;
            end
          end
          PH_KEY: begin
            if (midx_q >= MW'(klen_q) || data_byte_i != key_byte) begin
              phase_d = PH_BAD;
            end else begin
              midx_d = midx_q + MW'(1);
              if (midx_q + MW'(1) >= MW'(klen_q)) phase_d = PH_KEYSP;
            end
          end
          PH_KEYSP: begin
            if (data_byte_i == 8'h20) begin
              dseen_d = 1'b0; flags_d = '0;
              phase_d = (mask_q != 32'h0) ? PH_FNUM : PH_FANY;
            end else begin
              phase_d = PH_BAD;
            end
          end
          PH_FANY: begin
            if (data_byte_i == 8'h20) begin
              phase_d = PH_LEN; dseen_d = 1'b0; len_d = '0;
            end else if (data_byte_i == 8'h00) begin
              phase_d = PH_BAD;
            end
          end
          PH_FNUM: begin
            if (data_byte_i == 8'h20 && dseen_q) begin
              phase_d = PH_LEN; dseen_d = 1'b0; len_d = '0;
            end else if (is_digit && fprod[35:32] == 4'h0) begin
              flags_d = fprod[31:0]; dseen_d = 1'b1;
            end else begin
              phase_d = PH_BAD;
            end
          end
          PH_LEN: begin
            if (data_byte_i == 8'h0D && dseen_q) begin
              phase_d = PH_LENLF;
            end else if (is_digit && lprod[LB+3:LB] == 4'h0) begin
              len_d = lprod[LB-1:0]; dseen_d = 1'b1;
            end else begin
              phase_d = PH_BAD;
            end
          end
          default: phase_d = PH_BAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START; klen_q <= '0; midx_q <= '0; flags_q <= '0;
      len_q <= '0; rem_q <= '0; tidx_q <= '0; dseen_q <= 1'b0; mask_q <= '0;
    end else begin
      phase_q <= phase_d; klen_q <= klen_d; midx_q <= midx_d; flags_q <= flags_d;
      len_q <= len_d; rem_q <= rem_d; tidx_q <= tidx_d; dseen_q <= dseen_d;
      if (cfg_we_i) mask_q <= cfg_wdata_i;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/mcgrp_queue.sv
// Back end: short result queue towards the output channel
`default_nettype none
`include "assert_macros.svh"
module mcgrp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  mcgrp_pkg::res_t       push_data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output mcgrp_pkg::res_t       out_data_o
);
  import mcgrp_pkg::*;

  res_t       ent_q [QueueDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign full_o      = cnt_q == 2'(QueueDepth);
  assign out_data_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0; rptr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop)    rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= 2'(QueueDepth), "queue count overrun")
  `ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, !(push_i && full_o), "push into full queue")
  `ASSERT_NEXT(a_empty_holds, clk_i, rst_ni, cnt_q == 2'd0 && !push_i, cnt_q == 2'd0, "phantom entry")
endmodule
`default_nettype wire
